// ----- sv/atc_pkg.sv -----
// Shared types, codes and helper function of the answer typo classifier.
package atc_pkg;

  // Bounds of the ASCII digit range, both exclusive
  localparam logic [7:0] DigitLowExcl  = 8'd47;
  localparam logic [7:0] DigitHighExcl = 8'd58;

  // Upper-case ASCII range and the lower-casing offset
  localparam logic [7:0] UpperLow    = 8'd65;
  localparam logic [7:0] UpperHigh   = 8'd90;
  localparam logic [7:0] FoldOffset  = 8'd32;

  // Verdict codes
  typedef logic [1:0] verdict_t;
  localparam verdict_t VerdictCorrect = 2'd0;
  localparam verdict_t VerdictTypo    = 2'd1;
  localparam verdict_t VerdictWrong   = 2'd2;

  // Substitution count saturates here
  localparam logic [1:0] SubstMax = 2'd2;

  // Length gap is held in -2..2
  typedef logic signed [2:0] gap_t;
  localparam gap_t GapMax = 3'sd2;
  localparam gap_t GapMin = -3'sd2;
  localparam gap_t GapOne = 3'sd1;
  localparam gap_t GapNeg = -3'sd1;
  localparam gap_t GapNil = 3'sd0;

  // One position of the two answers
  typedef struct packed {
    logic [7:0] expected_char;
    logic       expected_here;
    logic [7:0] given_char;
    logic       given_here;
    logic       final_position;
  } item_t;

  // ASCII lower-casing of one byte
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UpperLow && c <= UpperHigh) begin
      r = c + FoldOffset;
    end
    return r;
  endfunction

endpackage

// ----- sv/answer_typo_classifier.sv -----
// Top level: input register, classification core and result register.
// A position accepted into the input register is classified as it leaves it, and the
// verdict of a last position is captured in the result register and held on verdict_o.
// Throughput: one position per cycle while no last position waits on a stalled verdict.
// Positions that are not last never wait on the output side.
// Reset (rst_ni low, asynchronous) empties both registers and returns the match state to the
// start of an answer.
module answer_typo_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] expected_char_i,
  input  logic       expected_here_i,
  input  logic [7:0] given_char_i,
  input  logic       given_here_i,
  input  logic       final_position_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o
);
  import atc_pkg::*;

  item_t    item_q;
  logic     s1_valid_q, s1_valid_d;
  logic     out_valid_q, out_valid_d;
  verdict_t verdict_q;
  verdict_t core_verdict;
  logic     accept, advance, out_free;

  // Handshake: the input stage drains unless a verdict has nowhere to go
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && (!item_q.final_position || out_free);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && item_q.final_position) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.expected_char  <= expected_char_i;
      item_q.expected_here  <= expected_here_i;
      item_q.given_char     <= given_char_i;
      item_q.given_here     <= given_here_i;
      item_q.final_position <= final_position_i;
    end
  end

  atc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .item_i    (item_q),
    .verdict_o (core_verdict)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_q.final_position) begin
      verdict_q <= core_verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && item_q.final_position && out_valid_q)
    else $error("input stalled without a blocked last position");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (verdict_q == VerdictCorrect || verdict_q == VerdictTypo ||
                     verdict_q == VerdictWrong))
    else $error("verdict code out of range");

  a_final_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.final_position |=> out_valid_q)
    else $error("last position did not produce a verdict");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !(advance && item_q.final_position))
    else $error("pending verdict overwritten");

endmodule

// ----- sv/atc_core.sv -----
// Per-position match tracking and verdict logic of the answer typo classifier.
module atc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  atc_pkg::item_t   item_i,
  output atc_pkg::verdict_t verdict_o
);
  import atc_pkg::*;

  logic [7:0] prev_expected_q, prev_expected_d;
  logic [7:0] prev_given_q, prev_given_d;
  logic       exact_q, exact_d;
  logic       folded_q, folded_d;
  logic [1:0] subst_q, subst_d;
  logic       del_ok_q, del_ok_d;
  logic       ins_ok_q, ins_ok_d;
  gap_t       gap_q, gap_d;
  logic       digit_first_q, digit_first_d;
  logic       at_start_q;

  logic [7:0] fe, fg;
  logic       eh, gh;
  logic       raw_match, fold_match;

  assign eh = item_i.expected_here;
  assign gh = item_i.given_here;
  assign fe = fold_case(item_i.expected_char);
  assign fg = fold_case(item_i.given_char);

  // Position compare: present bytes compare by value, absent ones by presence
  always_comb begin
    if (eh && gh) begin
      raw_match  = (item_i.expected_char == item_i.given_char);
      fold_match = (fe == fg);
    end else begin
      raw_match  = (eh == gh);
      fold_match = (eh == gh);
    end
  end

  // Running state after this position
  always_comb begin
    if (at_start_q) begin
      digit_first_d = eh && item_i.expected_char > DigitLowExcl &&
                      item_i.expected_char < DigitHighExcl;
    end else begin
      digit_first_d = digit_first_q;
    end
    // shifted alignments use the folded prefix match before this position
    del_ok_d = folded_q || (del_ok_q && eh && fe == prev_given_q);
    ins_ok_d = folded_q || (ins_ok_q && gh && fg == prev_expected_q);
    exact_d  = exact_q && raw_match;
    folded_d = folded_q && fold_match;
    subst_d  = (!fold_match && subst_q < SubstMax) ? subst_q + 2'd1 : subst_q;
    gap_d    = gap_q;
    if (eh && !gh && gap_q < GapMax) begin
      gap_d = gap_q + GapOne;
    end else if (gh && !eh && gap_q > GapMin) begin
      gap_d = gap_q - GapOne;
    end
    prev_expected_d = eh ? fe : 8'd0;
    prev_given_d    = gh ? fg : 8'd0;
  end

  // Verdict from the updated state
  always_comb begin
    if (exact_d && gap_d == GapNil) begin
      verdict_o = VerdictCorrect;
    end else if (digit_first_d) begin
      verdict_o = VerdictWrong;
    end else if (folded_d && gap_d == GapNil) begin
      verdict_o = VerdictCorrect;
    end else if ((gap_d == GapNil && subst_d == 2'd1) ||
                 (gap_d == GapOne && del_ok_d) ||
                 (gap_d == GapNeg && ins_ok_d)) begin
      verdict_o = VerdictTypo;
    end else begin
      verdict_o = VerdictWrong;
    end
  end

  // State registers; the last position returns everything to the start values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_expected_q <= '0;
      prev_given_q    <= '0;
      exact_q         <= 1'b1;
      folded_q        <= 1'b1;
      subst_q         <= '0;
      del_ok_q        <= 1'b1;
      ins_ok_q        <= 1'b1;
      gap_q           <= GapNil;
      digit_first_q   <= 1'b0;
      at_start_q      <= 1'b1;
    end else if (fire_i) begin
      if (item_i.final_position) begin
        prev_expected_q <= '0;
        prev_given_q    <= '0;
        exact_q         <= 1'b1;
        folded_q        <= 1'b1;
        subst_q         <= '0;
        del_ok_q        <= 1'b1;
        ins_ok_q        <= 1'b1;
        gap_q           <= GapNil;
        digit_first_q   <= 1'b0;
        at_start_q      <= 1'b1;
      end else begin
        prev_expected_q <= prev_expected_d;
        prev_given_q    <= prev_given_d;
        exact_q         <= exact_d;
        folded_q        <= folded_d;
        subst_q         <= subst_d;
        del_ok_q        <= del_ok_d;
        ins_ok_q        <= ins_ok_d;
        gap_q           <= gap_d;
        digit_first_q   <= digit_first_d;
        at_start_q      <= 1'b0;
      end
    end
  end

  // Checks
  a_gap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_q >= GapMin && gap_q <= GapMax)
    else $error("length gap out of range");

  a_subst_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    subst_q <= SubstMax)
    else $error("substitution count past saturation");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.final_position |=> at_start_q && exact_q && folded_q)
    else $error("state not restarted after last position");

  a_exact_implies_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exact_q |-> folded_q)
    else $error("exact match without folded match");

endmodule

// ----- tb/sv/tb_answer_typo_classifier.sv -----
// Self-checking testbench of the answer typo classifier: directed and random answers, scored in step.
`timescale 1ns / 1ps

module tb_answer_typo_classifier;
  import atc_pkg::*;

  localparam int HoldCycles      = 300;
  localparam int PhasePositions  = 320;
  localparam int PressureAnswers = 40;
  localparam int ReportLimit     = 10;

  // Ways of deriving the given answer from the expected one
  typedef enum logic [2:0] {
    EditNone, EditCase, EditSwap, EditDrop, EditAdd, EditTwo, EditFresh
  } edit_e;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic [7:0] expected_char_i  = '0;
  logic       expected_here_i  = 1'b0;
  logic [7:0] given_char_i     = '0;
  logic       given_here_i     = 1'b0;
  logic       final_position_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic [1:0] verdict_o;

  answer_typo_classifier i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .expected_char_i (expected_char_i),
    .expected_here_i (expected_here_i),
    .given_char_i    (given_char_i),
    .given_here_i    (given_here_i),
    .final_position_i(final_position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .verdict_o       (verdict_o)
  );

  always #4 clk_i = ~clk_i;

  // Stimulus and expectation stores
  item_t      pending_positions[$];
  verdict_t   verdicts_due[$];
  logic [7:0] word_exp[$];
  logic [7:0] word_giv[$];
  int         pushed      = 0;
  int         error_count = 0;

  // Idling controls, set per phase
  int   tx_gap_max = 8;
  int   rx_gap_max = 8;
  int   tx_wait    = 0;
  int   rx_wait    = 0;
  int   rx_draw;
  int   hold_left  = 0;
  logic hold_req   = 1'b0;
  logic hold_ack   = 1'b0;
  logic in_taken   = 1'b0;
  logic out_taken  = 1'b0;

  // Scoring state of the answer in flight
  logic [7:0] last_exp_lc;
  logic [7:0] last_giv_lc;
  logic       exact_ok;
  logic       folded_ok;
  logic [1:0] swap_count;
  logic       drop_ok;
  logic       add_ok;
  gap_t       len_gap;
  logic       digit_lead;
  logic       answer_start;
  item_t      seen_pos;
  verdict_t   want;

  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    return (c inside {[UpperLow:UpperHigh]}) ? (c | FoldOffset) : c;
  endfunction

  task automatic clear_answer();
    last_exp_lc  = '0;
    last_giv_lc  = '0;
    exact_ok     = 1'b1;
    folded_ok    = 1'b1;
    swap_count   = '0;
    drop_ok      = 1'b1;
    add_ok       = 1'b1;
    len_gap      = GapNil;
    digit_lead   = 1'b0;
    answer_start = 1'b1;
  endtask

  // Update the match state with one accepted position; queue a verdict on the last one
  task automatic score_position(input item_t pos);
    logic [7:0] exp_lc;
    logic [7:0] giv_lc;
    logic       same_raw;
    logic       same_lc;
    logic       drop_next;
    logic       add_next;
    verdict_t   call;
    exp_lc = lower_byte(pos.expected_char);
    giv_lc = lower_byte(pos.given_char);
    if (answer_start) begin
      digit_lead = pos.expected_here && pos.expected_char > DigitLowExcl &&
                   pos.expected_char < DigitHighExcl;
      answer_start = 1'b0;
    end
    if (pos.expected_here && pos.given_here) begin
      same_raw = (pos.expected_char == pos.given_char);
      same_lc  = (exp_lc == giv_lc);
    end else begin
      same_raw = (pos.expected_here == pos.given_here);
      same_lc  = same_raw;
    end
    // shifted alignments look at the folded prefix before this position
    drop_next = folded_ok || (drop_ok && pos.expected_here && exp_lc == last_giv_lc);
    add_next  = folded_ok || (add_ok && pos.given_here && giv_lc == last_exp_lc);
    drop_ok   = drop_next;
    add_ok    = add_next;
    exact_ok  = exact_ok && same_raw;
    folded_ok = folded_ok && same_lc;
    if (!same_lc && swap_count < SubstMax) swap_count++;
    if (pos.expected_here && !pos.given_here && len_gap < GapMax) len_gap++;
    else if (pos.given_here && !pos.expected_here && len_gap > GapMin) len_gap--;
    last_exp_lc = pos.expected_here ? exp_lc : '0;
    last_giv_lc = pos.given_here ? giv_lc : '0;
    if (pos.final_position) begin
      if (exact_ok && len_gap == GapNil) call = VerdictCorrect;
      else if (digit_lead) call = VerdictWrong;
      else if (folded_ok && len_gap == GapNil) call = VerdictCorrect;
      else if ((len_gap == GapNil && swap_count == 2'd1) ||
               (len_gap == GapOne && drop_ok) || (len_gap == GapNeg && add_ok))
        call = VerdictTypo;
      else call = VerdictWrong;
      verdicts_due.push_back(call);
      clear_answer();
    end
  endtask

  task automatic note_error(input string msg);
    if (error_count < ReportLimit) $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Character mix: mostly letters, some digits, case and digit boundaries, any byte
  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0, 1:    return 8'(UpperLow + $urandom_range(0, 25));
      2:       return 8'(DigitLowExcl + $urandom_range(0, 11));
      3:       return 8'($urandom);
      4:       return 8'(UpperLow + FoldOffset + $urandom_range(0, 2));
      5:       return $urandom_range(0, 1) ? 8'(UpperLow - 1) : 8'(UpperHigh + 1);
      default: return 8'(UpperLow + FoldOffset + $urandom_range(0, 25));
    endcase
  endfunction

  // Queue one answer pair, one position per byte of the longer answer
  task automatic push_pair();
    int    n;
    item_t it;
    n = (word_exp.size() > word_giv.size()) ? word_exp.size() : word_giv.size();
    if (n == 0) n = 1;
    for (int i = 0; i < n; i++) begin
      it.expected_here  = (i < word_exp.size());
      it.expected_char  = it.expected_here ? word_exp[i] : 8'($urandom);
      it.given_here     = (i < word_giv.size());
      it.given_char     = it.given_here ? word_giv[i] : 8'($urandom);
      it.final_position = (i == n - 1);
      pending_positions.push_back(it);
    end
    pushed += n;
  endtask

  task automatic load_text(input string e, input string g);
    word_exp.delete();
    word_giv.delete();
    for (int i = 0; i < e.len(); i++) word_exp.push_back(e[i]);
    for (int i = 0; i < g.len(); i++) word_giv.push_back(g[i]);
    push_pair();
  endtask

  // Random positions with random presence flags; holes and stray last flags included
  task automatic push_noise(input int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it = item_t'(19'($urandom));
      if (i == n - 1) it.final_position = 1'b1;
      pending_positions.push_back(it);
    end
    pushed += n;
  endtask

  task automatic apply_edit(input edit_e how);
    case (how)
      EditCase: begin
        foreach (word_giv[i])
          if (((word_giv[i] & ~FoldOffset) inside {[UpperLow:UpperHigh]}) &&
              $urandom_range(0, 1))
            word_giv[i] ^= FoldOffset;
      end
      EditSwap: begin
        if (word_giv.size() != 0)
          word_giv[$urandom_range(0, word_giv.size() - 1)] = rand_char();
      end
      EditDrop: begin
        if (word_giv.size() != 0) word_giv.delete($urandom_range(0, word_giv.size() - 1));
      end
      EditAdd: begin
        word_giv.insert($urandom_range(0, word_giv.size()), rand_char());
      end
      EditTwo: begin
        apply_edit(edit_e'($urandom_range(EditSwap, EditAdd)));
        apply_edit(edit_e'($urandom_range(EditSwap, EditAdd)));
      end
      EditFresh: begin
        word_giv.delete();
        repeat ($urandom_range(0, 7)) word_giv.push_back(rand_char());
      end
      default: ;
    endcase
  endtask

  task automatic random_answer();
    edit_e how;
    if ($urandom_range(0, 9) == 0) begin
      push_noise($urandom_range(1, 6));
    end else begin
      word_exp.delete();
      repeat ($urandom_range(0, 7)) word_exp.push_back(rand_char());
      if (word_exp.size() != 0 && $urandom_range(0, 4) == 0)
        word_exp[0] = 8'(DigitLowExcl + 1 + $urandom_range(0, 9));
      word_giv = word_exp;
      how = edit_e'($urandom_range(EditNone, EditFresh));
      apply_edit(how);
      if (how != EditNone && how != EditCase && $urandom_range(0, 2) == 0)
        apply_edit(EditCase);
      push_pair();
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_positions.size() != 0 || in_valid_i || verdicts_due.size() != 0);
  endtask

  // Sender: launch the next position after the drawn gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (tx_wait != 0) begin
        in_valid_i <= 1'b0;
        tx_wait    <= tx_wait - 1;
      end else if (pending_positions.size() != 0) begin
        expected_char_i  <= pending_positions[0].expected_char;
        expected_here_i  <= pending_positions[0].expected_here;
        given_char_i     <= pending_positions[0].given_char;
        given_here_i     <= pending_positions[0].given_here;
        final_position_i <= pending_positions[0].final_position;
        void'(pending_positions.pop_front());
        in_valid_i <= 1'b1;
        tx_wait    <= $urandom_range(0, tx_gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: long hold on request, else a drawn stall after each verdict
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait     <= rx_wait - 1;
      out_stall_i <= 1'b1;
    end else if (out_taken) begin
      rx_draw = $urandom_range(0, rx_gap_max);
      rx_wait     <= (rx_draw != 0) ? rx_draw - 1 : 0;
      out_stall_i <= (rx_draw != 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: score accepted positions, check accepted verdicts in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken  <= in_valid_i && !in_stall_o;
      out_taken <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) begin
        seen_pos = '{expected_char_i, expected_here_i, given_char_i, given_here_i,
                     final_position_i};
        score_position(seen_pos);
      end
      if (out_valid_o && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          note_error($sformatf("verdict %0d with none due", verdict_o));
        end else begin
          want = verdicts_due.pop_front();
          if (verdict_o !== want)
            note_error($sformatf("verdict expected %0d, got %0d", want, verdict_o));
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clear_answer();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed answers
    load_text("", "");
    load_text("Ab", "aB");
    load_text("7a", "7A");
    load_text("cat", "cut");
    load_text("cat", "ct");
    load_text("cat", "cart");
    load_text("", "x");
    load_text("ab", "");
    word_exp = '{8'hFF};
    word_giv = '{8'h00};
    push_pair();
    load_text("/b", "/B");
    // presence flags that come back after a gap
    pending_positions.push_back('{8'h61, 1'b1, 8'h61, 1'b1, 1'b0});
    pending_positions.push_back('{8'h00, 1'b0, 8'hFF, 1'b0, 1'b0});
    pending_positions.push_back('{8'h62, 1'b1, 8'h42, 1'b1, 1'b1});
    pushed += 3;
    wait_drained();

    // Random phases with varying idling on both sides
    for (int ph = 0; ph < 6; ph++) begin
      tx_gap_max = (ph % 2 == 0) ? 8 : 0;
      rx_gap_max = (ph % 3 == 0) ? 0 : 8;
      for (int stop = pushed + PhasePositions; pushed < stop; ) random_answer();
      wait_drained();
      // back pressure: receiver holds off while the sender keeps offering
      if (ph == 1) begin
        tx_gap_max = 0;
        hold_req   = ~hold_req;
        repeat (PressureAnswers) begin
          word_exp = '{rand_char()};
          word_giv = '{rand_char()};
          push_pair();
        end
        wait_drained();
      end
    end

    repeat (20) @(posedge clk_i);
    if (verdicts_due.size() != 0)
      note_error($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
